/* rtl/bevt_pkg.sv */
// Shared types, constants and helper functions of the bond energy and virial tally unit.
package bevt_pkg;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CFG_E_GLOB  = 3'd0,
    CFG_E_ATOM  = 3'd1,
    CFG_V_GLOB  = 3'd2,
    CFG_V_ATOM  = 3'd3,
    CFG_NEWTON  = 3'd4,
    CFG_LOCAL   = 3'd5,
    CFG_GHOST   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SCALAR = 2'd0,
    OP_XYZ    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic        e_glob;
    logic        e_atom;
    logic        v_glob;
    logic        v_atom;
    logic        newton;
    logic [12:0] local_count;
    logic [12:0] ghost_count;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [11:0]        ai;
    logic [11:0]        aj;
    logic               ii;
    logic               jj;
    logic signed [31:0] energy;
    logic signed [31:0] scale;
    logic [2:0][31:0]   f;
    logic [2:0][31:0]   d;
  } item_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MUL_A, S_MUL_LO, S_MUL_HI, S_SUM, S_FIN,
    S_GLOB1, S_GLOB2, S_AT_RD, S_AT_WR, S_CLR, S_RD, S_DONE
  } state_t;

  // Displacement index of the first factor of each virial component.
  function automatic logic [1:0] comp_a(input logic [2:0] c);
    logic [1:0] r;
    unique case (c)
      3'd1, 3'd5: r = 2'd1;
      3'd2:       r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // Index of the second factor of each virial component.
  function automatic logic [1:0] comp_b(input logic [2:0] c);
    logic [1:0] r;
    unique case (c)
      3'd1, 3'd3: r = 2'd1;
      3'd2, 3'd4, 3'd5: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

/* rtl/bevt_queue.sv */
// Two-entry queue that carries classified items from the front to the back.
module bevt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bevt_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bevt_pkg::item_t head
);
  import bevt_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

endmodule

/* rtl/bevt_front.sv */
// Front end: accepts items from the input channel and classifies them for the queue.
module bevt_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [11:0]        atom_i,
  input  logic [11:0]        atom_j,
  input  logic signed [31:0] bond_energy,
  input  logic signed [31:0] force_scale,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] disp_x,
  input  logic signed [31:0] disp_y,
  input  logic signed [31:0] disp_z,
  input  logic [12:0]        local_count,
  input  logic               q_full,
  input  logic               init_busy,
  output logic               push,
  output bevt_pkg::item_t    push_item
);
  import bevt_pkg::*;

  assign in_stall = q_full | init_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_item        = '0;
    push_item.op     = op_t'(cmd);
    push_item.ai     = atom_i;
    push_item.aj     = atom_j;
    // Ownership of each atom is settled here, once per item.
    push_item.ii     = {1'b0, atom_i} < local_count;
    push_item.jj     = {1'b0, atom_j} < local_count;
    push_item.energy = bond_energy;
    push_item.scale  = force_scale;
    push_item.f      = {force_z, force_y, force_x};
    push_item.d      = {disp_z, disp_y, disp_x};
  end

endmodule

/* rtl/bevt_back.sv */
// Back end: multiplier sequencer, global totals, per-atom stores and result register.
module bevt_back #(
  parameter int ATOMS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  bevt_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  bevt_pkg::item_t    q_head,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [63:0] energy_out,
  output logic signed [63:0] vir_xx,
  output logic signed [63:0] vir_yy,
  output logic signed [63:0] vir_zz,
  output logic signed [63:0] vir_xy,
  output logic signed [63:0] vir_xz,
  output logic signed [63:0] vir_yz
);
  import bevt_pkg::*;

  localparam int AW = (ATOMS > 1) ? $clog2(ATOMS) : 1;
  localparam int CW = AW + 1;

  state_t state, state_next;

  item_t              cur;
  logic [2:0]         comp;
  logic               sel;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      ncap;
  logic               sign_r;
  logic [63:0]        prod;
  logic [63:0]        p_lo;
  logic [63:0]        p_hi;
  logic [95:0]        psum;
  logic signed [63:0] vf [6];
  logic signed [63:0] vh [6];
  logic signed [63:0] tot_e;
  logic signed [63:0] tot_v [6];
  logic               rd_zero;

  logic [63:0]  mem_e [ATOMS];
  logic [383:0] mem_v [ATOMS];
  logic [63:0]  rdata_e;
  logic [383:0] rdata_v;

  logic          re;
  logic [AW-1:0] raddr;
  logic          we_e;
  logic          we_v;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata_e;
  logic [383:0]  wdata_v;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        fm;
  logic               mul_sign;
  logic signed [63:0] ef;
  logic signed [63:0] eh;
  logic [11:0]        at_idx;
  logic [31:0]        at_ext;
  logic               at_do;
  logic [31:0]        rd_ext;
  logic               out_take;
  logic [13:0]        nsum;
  logic [31:0]        ncap_w;

  function automatic logic signed [63:0] shift_sat(input logic [79:0] q,
                                                    input logic rem,
                                                    input logic neg);
    logic [79:0]        qm;
    logic signed [63:0] r;
    qm = q + {79'd0, neg & rem};
    if (neg) begin
      r = (qm > {16'd0, 64'h8000_0000_0000_0000}) ? SAT_MIN : -$signed(qm[63:0]);
    end else begin
      r = (qm > {16'd0, 64'h7FFF_FFFF_FFFF_FFFF}) ? SAT_MAX : $signed(qm[63:0]);
    end
    return r;
  endfunction

  assign ef = {{16{cur.energy[31]}}, cur.energy, 16'd0};
  assign eh = {{17{cur.energy[31]}}, cur.energy, 15'd0};

  assign mul_a    = mag32(cur.d[comp_a(comp)]);
  assign mul_b    = (cur.op == OP_XYZ) ? mag32(cur.f[comp_b(comp)]) : mag32(cur.d[comp_b(comp)]);
  assign mul_sign = (cur.op == OP_XYZ) ? (cur.d[comp_a(comp)][31] ^ cur.f[comp_b(comp)][31])
                                       : (cur.d[comp_a(comp)][31] ^ cur.d[comp_b(comp)][31]
                                          ^ cur.scale[31]);
  assign fm       = mag32(cur.scale);

  assign at_idx = sel ? cur.aj : cur.ai;
  assign at_ext = {20'd0, at_idx};
  assign at_do  = (cfg.newton | (sel ? cur.jj : cur.ii)) & (at_ext < 32'(ATOMS));
  assign rd_ext = {20'd0, cur.ai};

  assign out_take  = out_valid & ~out_stall;
  assign init_busy = (state == S_INIT);

  assign nsum   = {1'b0, cfg.local_count} + (cfg.newton ? {1'b0, cfg.ghost_count} : 14'd0);
  assign ncap_w = ({18'd0, nsum} > 32'(ATOMS)) ? 32'(ATOMS) : {18'd0, nsum};

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    re         = 1'b0;
    raddr      = at_ext[AW-1:0];
    we_e       = 1'b0;
    we_v       = 1'b0;
    waddr      = at_ext[AW-1:0];
    wdata_e    = '0;
    wdata_v    = '0;
    unique case (state)
      S_INIT: begin
        we_e  = 1'b1;
        we_v  = 1'b1;
        waddr = cnt[AW-1:0];
        if (32'(cnt) == 32'(ATOMS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_SCALAR, OP_XYZ: state_next = S_MUL_A;
            OP_CLEAR:          state_next = S_CLR;
            OP_READ:           state_next = S_RD;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_A:  state_next = (cur.op == OP_XYZ) ? S_FIN : S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SUM;
      S_SUM:    state_next = S_FIN;
      S_FIN:    state_next = (comp == 3'd5) ? S_GLOB1 : S_MUL_A;
      S_GLOB1:  state_next = S_GLOB2;
      S_GLOB2:  state_next = S_AT_RD;
      S_AT_RD: begin
        if (at_do) begin
          re         = 1'b1;
          state_next = S_AT_WR;
        end else if (sel) begin
          state_next = S_DONE;
        end
      end
      S_AT_WR: begin
        we_e    = cfg.e_atom;
        we_v    = cfg.v_atom;
        wdata_e = sat_add(rdata_e, eh);
        for (int c = 0; c < 6; c++) begin
          wdata_v[64*c +: 64] = sat_add(rdata_v[64*c +: 64], vh[c]);
        end
        state_next = sel ? S_DONE : S_AT_RD;
      end
      S_CLR: begin
        waddr = cnt[AW-1:0];
        if (cnt < ncap) begin
          we_e = cfg.e_atom;
          we_v = cfg.v_atom;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RD: begin
        raddr      = rd_ext[AW-1:0];
        re         = (rd_ext < 32'(ATOMS));
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
      tot_e     <= '0;
      for (int c = 0; c < 6; c++) begin
        tot_v[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_take && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          cnt <= (32'(cnt) == 32'(ATOMS - 1)) ? '0 : cnt + CW'(1);
        end
        S_IDLE: begin
          if (q_valid) begin
            cur  <= q_head;
            comp <= 3'd0;
            sel  <= 1'b0;
            cnt  <= '0;
            ncap <= ncap_w[CW-1:0];
            if (q_head.op == OP_CLEAR) begin
              if (cfg.e_glob) begin
                tot_e <= '0;
              end
              if (cfg.v_glob) begin
                for (int c = 0; c < 6; c++) begin
                  tot_v[c] <= '0;
                end
              end
            end
          end
        end
        S_MUL_A: begin
          prod   <= {32'd0, mul_a} * {32'd0, mul_b};
          sign_r <= mul_sign;
        end
        S_MUL_LO: p_lo <= {32'd0, prod[31:0]} * {32'd0, fm};
        S_MUL_HI: p_hi <= {32'd0, prod[63:32]} * {32'd0, fm};
        S_SUM:    psum <= {32'd0, p_lo} + {p_hi, 32'd0};
        S_FIN: begin
          if (cur.op == OP_XYZ) begin
            vf[comp] <= sign_r ? -$signed(prod) : $signed(prod);
            vh[comp] <= (sign_r ? -$signed(prod) : $signed(prod)) >>> 1;
          end else begin
            // A zero displacement product carries no sign.
            vf[comp] <= shift_sat(psum[95:16], |psum[15:0], sign_r & (prod != 64'd0));
            vh[comp] <= shift_sat({1'b0, psum[95:17]}, |psum[16:0],
                                  sign_r & (prod != 64'd0));
          end
          comp <= comp + 3'd1;
        end
        S_GLOB1: begin
          if (cfg.e_glob) begin
            tot_e <= sat_add(tot_e, cfg.newton ? ef : (cur.ii ? eh : 64'sd0));
          end
          if (cfg.v_glob) begin
            for (int c = 0; c < 6; c++) begin
              tot_v[c] <= sat_add(tot_v[c], cfg.newton ? vf[c] : (cur.ii ? vh[c] : 64'sd0));
            end
          end
        end
        S_GLOB2: begin
          if (!cfg.newton && cur.jj) begin
            if (cfg.e_glob) begin
              tot_e <= sat_add(tot_e, eh);
            end
            if (cfg.v_glob) begin
              for (int c = 0; c < 6; c++) begin
                tot_v[c] <= sat_add(tot_v[c], vh[c]);
              end
            end
          end
        end
        S_AT_RD: begin
          if (!at_do) begin
            sel <= 1'b1;
          end
        end
        S_AT_WR: sel <= 1'b1;
        S_CLR: begin
          if (cnt < ncap) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_RD: rd_zero <= ~(rd_ext < 32'(ATOMS));
        S_DONE: begin
          if (!out_valid || out_take) begin
            out_valid <= 1'b1;
            if (cur.op == OP_READ) begin
              kind       <= 1'b1;
              energy_out <= rd_zero ? 64'sd0 : $signed(rdata_e);
              vir_xx     <= rd_zero ? 64'sd0 : $signed(rdata_v[63:0]);
              vir_yy     <= rd_zero ? 64'sd0 : $signed(rdata_v[127:64]);
              vir_zz     <= rd_zero ? 64'sd0 : $signed(rdata_v[191:128]);
              vir_xy     <= rd_zero ? 64'sd0 : $signed(rdata_v[255:192]);
              vir_xz     <= rd_zero ? 64'sd0 : $signed(rdata_v[319:256]);
              vir_yz     <= rd_zero ? 64'sd0 : $signed(rdata_v[383:320]);
            end else begin
              kind       <= 1'b0;
              energy_out <= tot_e;
              vir_xx     <= tot_v[0];
              vir_yy     <= tot_v[1];
              vir_zz     <= tot_v[2];
              vir_xy     <= tot_v[3];
              vir_xz     <= tot_v[4];
              vir_yz     <= tot_v[5];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_e <= mem_e[raddr];
      rdata_v <= mem_v[raddr];
    end
    if (we_e) begin
      mem_e[waddr] <= wdata_e;
    end
    if (we_v) begin
      mem_v[waddr] <= wdata_v;
    end
  end

endmodule

/* rtl/bond_energy_virial_tally_unit.sv */
// Top level of the bond energy and virial tally unit with its configuration registers.
//
// Items arrive on the input channel (in_valid / in_stall) and each one produces exactly
// one item on the output channel (out_valid / out_stall). A scalar or xyz tally and a
// clear answer with the global totals after the update (kind 0); a read answers with the
// addressed atom's energy and virial (kind 1).
// The front end classifies an item and places it in a two-entry queue; the back end takes
// items from the queue one at a time. Its 32x32 multiplies set the tally time: a scalar
// tally steps through S_MUL_A, S_MUL_LO, S_MUL_HI, S_SUM and S_FIN for each virial
// component, an xyz tally through S_MUL_A and S_FIN; an atom that takes no share
// skips its write step. A clear sweeps the cleared atoms, a read the addressed atom.
// After reset the per-atom memories are swept to zero, one atom per cycle, over all
// ATOMS entries; in_stall stays high meanwhile, although configuration writes are taken.
// A finished result sits in the output register until taken; while the receiver stalls,
// the back end carries on with the next queued item and waits only to deliver it, and
// the input channel stalls once the queue is full.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must write it
// only while the unit is idle, as the unit itself does not enforce this.
module bond_energy_virial_tally_unit #(
  parameter int ATOMS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [11:0]        atom_i,
  input  logic [11:0]        atom_j,
  input  logic signed [31:0] bond_energy,
  input  logic signed [31:0] force_scale,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] disp_x,
  input  logic signed [31:0] disp_y,
  input  logic signed [31:0] disp_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [63:0] energy_out,
  output logic signed [63:0] vir_xx,
  output logic signed [63:0] vir_yy,
  output logic signed [63:0] vir_zz,
  output logic signed [63:0] vir_xy,
  output logic signed [63:0] vir_xz,
  output logic signed [63:0] vir_yz
);
  import bevt_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;
  logic  init_busy;

  // Register values are masked to their widths; unknown indices are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_E_GLOB: cfg.e_glob      <= cfg_data[0];
        CFG_E_ATOM: cfg.e_atom      <= cfg_data[0];
        CFG_V_GLOB: cfg.v_glob      <= cfg_data[0];
        CFG_V_ATOM: cfg.v_atom      <= cfg_data[0];
        CFG_NEWTON: cfg.newton      <= cfg_data[0];
        CFG_LOCAL:  cfg.local_count <= cfg_data;
        CFG_GHOST:  cfg.ghost_count <= cfg_data;
        default: ;
      endcase
    end
  end

  bevt_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .atom_i      (atom_i),
    .atom_j      (atom_j),
    .bond_energy (bond_energy),
    .force_scale (force_scale),
    .force_x     (force_x),
    .force_y     (force_y),
    .force_z     (force_z),
    .disp_x      (disp_x),
    .disp_y      (disp_y),
    .disp_z      (disp_z),
    .local_count (cfg.local_count),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .push        (push),
    .push_item   (push_item)
  );

  bevt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bevt_back #(
    .ATOMS (ATOMS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .energy_out (energy_out),
    .vir_xx     (vir_xx),
    .vir_yy     (vir_yy),
    .vir_zz     (vir_zz),
    .vir_xy     (vir_xy),
    .vir_xz     (vir_xz),
    .vir_yz     (vir_yz)
  );

endmodule

/* tb/tb_bond_energy_virial_tally_unit.sv */
// Self-checking testbench of the bond energy and virial tally unit.
module tb_bond_energy_virial_tally_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bevt_pkg::*;

  // Size of the per-atom stores, the run limit and the settling time at the end.
  localparam int NATOMS = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 200;
  localparam int RAND_ITEMS = 1200;

  // One input item as the stimulus side sees it.
  typedef struct {
    op_t                op;
    logic [11:0]        ai;
    logic [11:0]        aj;
    logic signed [31:0] energy;
    logic signed [31:0] scale;
    logic signed [31:0] f[3];
    logic signed [31:0] d[3];
  } bond_item_t;

  // One result item: a kind bit and seven Q32.32 words.
  typedef struct {
    logic               kind;
    logic signed [63:0] energy;
    logic signed [63:0] vir[6];
  } tally_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [12:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic [11:0]        atom_i = '0;
  logic [11:0]        atom_j = '0;
  logic signed [31:0] bond_energy = '0;
  logic signed [31:0] force_scale = '0;
  logic signed [31:0] force_x = '0;
  logic signed [31:0] force_y = '0;
  logic signed [31:0] force_z = '0;
  logic signed [31:0] disp_x = '0;
  logic signed [31:0] disp_y = '0;
  logic signed [31:0] disp_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic signed [63:0] energy_out;
  logic signed [63:0] vir_xx, vir_yy, vir_zz, vir_xy, vir_xz, vir_yz;

  bond_energy_virial_tally_unit #(.ATOMS(NATOMS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .atom_i(atom_i), .atom_j(atom_j),
    .bond_energy(bond_energy), .force_scale(force_scale),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .energy_out(energy_out),
    .vir_xx(vir_xx), .vir_yy(vir_yy), .vir_zz(vir_zz),
    .vir_xy(vir_xy), .vir_xz(vir_xz), .vir_yz(vir_yz)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the block's registers and accumulators, kept in step with accepted items.
  logic               mir_e_glob, mir_e_atom, mir_v_glob, mir_v_atom, mir_newton;
  logic [12:0]        mir_local, mir_ghost;
  logic signed [63:0] sum_energy;
  logic signed [63:0] sum_virial[6];
  logic signed [63:0] atom_energy[NATOMS];
  logic signed [63:0] atom_virial[NATOMS][6];

  tally_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  error_count = 0;
  int  results_seen = 0;
  int  reads_seen = 0;
  int  clears_sent = 0;
  int  cycle_count = 0;

  // Saturating signed 64-bit addition.
  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  // Clamp a wide signed value into the 64-bit range.
  function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
    if (v[127:63] == '0 || v[127:63] == '1) begin
      return v[63:0];
    end
    return v[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  endfunction

  // Displacement index of the first factor and index of the second factor of virial component c.
  function automatic int first_axis(input int c);
    case (c)
      1, 5: return 1;
      2: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int second_axis(input int c);
    case (c)
      1, 3: return 1;
      2, 4, 5: return 2;
      default: return 0;
    endcase
  endfunction

  // Add one atom's half share of energy and virial to its per-atom entry.
  function automatic void add_to_atom(input logic [11:0] a, input logic signed [63:0] eh,
                                      input logic signed [63:0] vh[6]);
    if (mir_e_atom) begin
      atom_energy[a] = add_clamped(atom_energy[a], eh);
    end
    if (mir_v_atom) begin
      for (int c = 0; c < 6; c++) atom_virial[a][c] = add_clamped(atom_virial[a][c], vh[c]);
    end
  endfunction

  // Apply one accepted item to the mirror and return the result it must produce.
  function automatic tally_result_t apply_bond_item(input bond_item_t it);
    tally_result_t r;
    logic signed [63:0] ef, eh;
    logic signed [63:0] vf[6], vh[6];
    logic signed [127:0] p;
    logic signed [63:0] x, y;
    logic ii, jj;
    int n;
    r.kind = 1'b0;
    if (it.op == OP_READ) begin
      r.kind = 1'b1;
      r.energy = atom_energy[it.ai];
      for (int c = 0; c < 6; c++) r.vir[c] = atom_virial[it.ai][c];
      return r;
    end
    if (it.op == OP_CLEAR) begin
      n = mir_local + (mir_newton ? mir_ghost : 13'd0);
      if (n > NATOMS) n = NATOMS;
      if (mir_e_glob) sum_energy = '0;
      if (mir_v_glob) begin
        for (int c = 0; c < 6; c++) sum_virial[c] = '0;
      end
      for (int a = 0; a < n; a++) begin
        if (mir_e_atom) atom_energy[a] = '0;
        if (mir_v_atom) begin
          for (int c = 0; c < 6; c++) atom_virial[a][c] = '0;
        end
      end
    end else begin
      ii = it.ai < mir_local;
      jj = it.aj < mir_local;
      ef = 64'(it.energy) <<< 16;
      eh = 64'(it.energy) <<< 15;
      for (int c = 0; c < 6; c++) begin
        x = it.d[first_axis(c)];
        if (it.op == OP_XYZ) begin
          y = it.f[second_axis(c)];
          vf[c] = x * y;
          vh[c] = vf[c] >>> 1;
        end else begin
          y = it.d[second_axis(c)];
          p = 128'(x) * 128'(y) * 128'(it.scale);
          vf[c] = clamp64(p >>> 16);
          vh[c] = clamp64(p >>> 17);
        end
      end
      if (mir_e_glob) begin
        if (mir_newton) sum_energy = add_clamped(sum_energy, ef);
        else begin
          if (ii) sum_energy = add_clamped(sum_energy, eh);
          if (jj) sum_energy = add_clamped(sum_energy, eh);
        end
      end
      if (mir_v_glob) begin
        for (int c = 0; c < 6; c++) begin
          if (mir_newton) sum_virial[c] = add_clamped(sum_virial[c], vf[c]);
          else begin
            if (ii) sum_virial[c] = add_clamped(sum_virial[c], vh[c]);
            if (jj) sum_virial[c] = add_clamped(sum_virial[c], vh[c]);
          end
        end
      end
      // The first atom takes its half before the second, which matters on saturation.
      if (mir_newton || ii) add_to_atom(it.ai, eh, vh);
      if (mir_newton || jj) add_to_atom(it.aj, eh, vh);
    end
    r.energy = sum_energy;
    for (int c = 0; c < 6; c++) r.vir[c] = sum_virial[c];
    return r;
  endfunction

  // Present one item, hold it until accepted, and queue its expected result.
  // The valid line is left high so that back-to-back items need no gap.
  task automatic send_item(input bond_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= it.op;
    atom_i <= it.ai;
    atom_j <= it.aj;
    bond_energy <= it.energy;
    force_scale <= it.scale;
    force_x <= it.f[0];
    force_y <= it.f[1];
    force_z <= it.f[2];
    disp_x <= it.d[0];
    disp_y <= it.d[1];
    disp_z <= it.d[2];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_CLEAR) clears_sent++;
    expected_results.push_back(apply_bond_item(it));
  endtask

  // Wait until every expected result has come back and the block has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; the enable is dropped by the caller after the last write.
  task automatic write_reg(input cfg_idx_t idx, input logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_E_GLOB: mir_e_glob = value[0];
      CFG_E_ATOM: mir_e_atom = value[0];
      CFG_V_GLOB: mir_v_glob = value[0];
      CFG_V_ATOM: mir_v_atom = value[0];
      CFG_NEWTON: mir_newton = value[0];
      CFG_LOCAL:  mir_local = value;
      CFG_GHOST:  mir_ghost = value;
      default: ;
    endcase
  endtask

  // Rewrite every register; only called while the block is idle.
  task automatic set_config(input logic eg, input logic ea, input logic vg, input logic va,
                            input logic nw, input logic [12:0] nloc, input logic [12:0] ngh);
    write_reg(CFG_E_GLOB, {12'd0, eg});
    write_reg(CFG_E_ATOM, {12'd0, ea});
    write_reg(CFG_V_GLOB, {12'd0, vg});
    write_reg(CFG_V_ATOM, {12'd0, va});
    write_reg(CFG_NEWTON, {12'd0, nw});
    write_reg(CFG_LOCAL, nloc);
    write_reg(CFG_GHOST, ngh);
    cfg_we <= 1'b0;
  endtask

  function automatic bond_item_t make_item(input op_t op, input logic [11:0] ai,
                                           input logic [11:0] aj,
                                           input logic signed [31:0] v);
    bond_item_t it;
    it.op = op;
    it.ai = ai;
    it.aj = aj;
    it.energy = v;
    it.scale = v;
    for (int c = 0; c < 3; c++) begin
      it.f[c] = v;
      it.d[c] = v;
    end
    return it;
  endfunction

  // A Q16.16 value: full-range random, shifted down often so that most sums stay in range.
  function automatic logic signed [31:0] rand_q();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 24);
  endfunction

  function automatic logic [11:0] rand_atom();
    if ($urandom_range(0, 99) < 85) return 12'($urandom_range(0, 15));
    return 12'($urandom_range(0, NATOMS - 1));
  endfunction

  function automatic bond_item_t rand_item();
    bond_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.op = OP_SCALAR;
    else if (pick < 80) it.op = OP_XYZ;
    else if (pick < 97) it.op = OP_READ;
    else it.op = OP_CLEAR;
    it.ai = rand_atom();
    it.aj = ($urandom_range(0, 9) == 0) ? it.ai : rand_atom();
    it.energy = rand_q();
    it.scale = rand_q();
    for (int c = 0; c < 3; c++) begin
      it.f[c] = rand_q();
      it.d[c] = rand_q();
    end
    return it;
  endfunction

  // Fresh store: the first and the last atom must read as zero, then one scalar tally.
  task automatic test_initial_reads();
    send_item(make_item(OP_READ, 12'd0, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd4095, 12'd0, 32'sd0));
    send_item(make_item(OP_SCALAR, 12'd0, 12'd1, 32'sh0001_0000));
    drain_results();
  endtask

  // Field extremes, saturation, a bond to itself, local and non-local atoms, clears.
  task automatic test_directed();
    bond_item_t it;
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 13'd4, 13'd2);
    send_item(make_item(OP_SCALAR, 12'd1, 12'd2, 32'sh7FFF_FFFF));
    send_item(make_item(OP_SCALAR, 12'd1, 12'd2, 32'sh8000_0000));
    send_item(make_item(OP_XYZ, 12'd3, 12'd3, 32'sh8000_0000));
    send_item(make_item(OP_XYZ, 12'd4095, 12'd0, 32'sh7FFF_FFFF));
    send_item(make_item(OP_XYZ, 12'd0, 12'd5, 32'shFFFF_FFFF));
    it = make_item(OP_SCALAR, 12'd2, 12'd3, 32'sh0000_8000);
    it.scale = 32'shFFFF_FFFF;
    it.d[1] = 32'sh8000_0000;
    send_item(it);
    send_item(make_item(OP_READ, 12'd3, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd4095, 12'd0, 32'sd0));
    send_item(make_item(OP_CLEAR, 12'd0, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd3, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd4095, 12'd0, 32'sd0));
    drain_results();
    // Without the newton mode only local atoms count, so atom 7 gets nothing here.
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 13'd4, 13'd8191);
    send_item(make_item(OP_SCALAR, 12'd1, 12'd7, 32'sh0003_0000));
    send_item(make_item(OP_XYZ, 12'd7, 12'd8, 32'sh0002_0000));
    send_item(make_item(OP_READ, 12'd7, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd1, 12'd0, 32'sd0));
    drain_results();
    // All sums disabled: tallies and a clear must leave the sums alone.
    set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 13'd8191, 13'd0);
    send_item(make_item(OP_XYZ, 12'd1, 12'd1, 32'sh0004_0000));
    send_item(make_item(OP_CLEAR, 12'd0, 12'd0, 32'sd0));
    send_item(make_item(OP_READ, 12'd1, 12'd0, 32'sd0));
    drain_results();
  endtask

  // Random traffic under a range of register settings and idling patterns.
  task automatic test_random();
    int per_phase;
    per_phase = RAND_ITEMS / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 13'd8, 13'd8);
        1: set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 13'd8, 13'd4096);
        2: set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 13'd4096, 13'd0);
        3: set_config(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 13'd0, 13'd4096);
        4: set_config(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 13'd0);
        5: set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 13'd4096, 13'd4096);
        6: set_config(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 13'd12, 13'd3);
        default: set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 13'd5, 13'd10);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int k = 0; k < per_phase; k++) send_item(rand_item());
      drain_results();
    end
  endtask

  // Output side: random stalls and a check of each item taken against the oldest expectation.
  always @(posedge clk) begin
    tally_result_t want;
    logic signed [63:0] got[6];
    logic bad;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      got = '{vir_xx, vir_yy, vir_zz, vir_xy, vir_xz, vir_yz};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Unexpected result item, kind %0d", kind);
      end else begin
        want = expected_results.pop_front();
        if (want.kind) reads_seen++;
        bad = (kind !== want.kind) || (energy_out !== want.energy);
        for (int c = 0; c < 6; c++) bad = bad || (got[c] !== want.vir[c]);
        if (bad) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch on result %0d: kind %0d/%0d energy %h/%h", results_seen,
                     want.kind, kind, want.energy, energy_out);
            for (int c = 0; c < 6; c++) $display("  virial %0d expected %h got %h", c,
                                                 want.vir[c], got[c]);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    mir_e_glob = 1'b0; mir_e_atom = 1'b0; mir_v_glob = 1'b0; mir_v_atom = 1'b0;
    mir_newton = 1'b0; mir_local = '0; mir_ghost = '0;
    sum_energy = '0;
    for (int c = 0; c < 6; c++) sum_virial[c] = '0;
    for (int a = 0; a < NATOMS; a++) begin
      atom_energy[a] = '0;
      for (int c = 0; c < 6; c++) atom_virial[a][c] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_initial_reads();
    test_directed();
    test_random();
    if (expected_results.size() != 0) error_count++;
    $display("Checked %0d result items (%0d atom reads, %0d clears) over eight settings,",
             results_seen, reads_seen, clears_sent);
    $display("with scalar and xyz tallies, saturation and idling on both channels.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
